@@ sv/bdq_pkg.sv @@
// Package for the bounded deque: depth, field widths, command and status codes,
// the controller/datapath command and status structs, and the index wrap helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

  localparam int DEPTH  = 8;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int CMD_W  = 3;
  localparam int ST_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_LIST       = 3'd4;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            push_front;
    logic            push_rear;
    logic            pop_front;
    logic            pop_rear;
    logic            list_start;
    logic            list_next;
    logic            load_status;
    logic [ST_W-1:0] status_code;
    logic            load_rdata;
    logic            rdata_last;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic list_end;
    logic out_last;
  } dp_stat_t;

  // Adds an offset of at most DEPTH to an index and wraps it around the buffer.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (s >= (CNT_W + 1)'(DEPTH)) begin
      s = s - (CNT_W + 1)'(DEPTH);
    end
    return s[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/bdq_in_if.sv @@
// Request channel of the bounded deque: valid/ready handshake with command and word.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bdq_in_if
  import bdq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [WORD_W-1:0] value_in;

  modport source (output valid, output cmd, output value_in, input ready);
  modport sink   (input valid, input cmd, input value_in, output ready);
endinterface

`default_nettype wire

@@ sv/bdq_out_if.sv @@
// Result channel of the bounded deque: valid/ready handshake with word, status, last.
// Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface bdq_out_if
  import bdq_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] value_out;
  logic [ST_W-1:0]          status;
  logic                     last;

  modport source (output valid, output value_out, output status, output last, input ready);
  modport sink   (input valid, input value_out, input status, input last, output ready);
endinterface

`default_nettype wire

@@ sv/bdq_dp.sv @@
// Datapath of the bounded deque: word memory, head index, item count, list offset
// and the result register. Driven by bdq_ctrl commands; depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_dp
  import bdq_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire dp_cmd_t                  cmd,
  input  wire logic signed [WORD_W-1:0] value_in,
  output dp_stat_t                      stat,
  output logic signed [WORD_W-1:0]      value_out,
  output logic [ST_W-1:0]               status,
  output logic                          last
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata;

  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] offset, offset_next;

  logic             mem_wr;
  logic [IDX_W-1:0] waddr;
  logic             mem_rd;
  logic [IDX_W-1:0] raddr;

  always_comb begin
    head_next   = head;
    count_next  = count;
    offset_next = offset;
    mem_wr      = 1'b0;
    waddr       = head;
    mem_rd      = 1'b0;
    raddr       = head;
    if (cmd.push_front) begin
      head_next  = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
      waddr      = head_next;
      mem_wr     = 1'b1;
      count_next = count + CNT_W'(1);
    end
    if (cmd.push_rear) begin
      waddr      = wrap_add(head, count);
      mem_wr     = 1'b1;
      count_next = count + CNT_W'(1);
    end
    if (cmd.pop_front) begin
      raddr      = head;
      mem_rd     = 1'b1;
      head_next  = wrap_add(head, CNT_W'(1));
      count_next = count - CNT_W'(1);
    end
    if (cmd.pop_rear) begin
      raddr      = wrap_add(head, count - CNT_W'(1));
      mem_rd     = 1'b1;
      count_next = count - CNT_W'(1);
    end
    if (cmd.list_start) begin
      offset_next = '0;
      raddr       = head;
      mem_rd      = 1'b1;
    end
    if (cmd.list_next) begin
      offset_next = offset + IDX_W'(1);
      raddr       = wrap_add(head, CNT_W'(offset) + CNT_W'(1));
      mem_rd      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    offset <= offset_next;
  end

  always_ff @(posedge clk) begin
    if (mem_wr) begin
      mem[waddr] <= value_in;
    end
    if (mem_rd) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_status) begin
      value_out <= '0;
      status    <= cmd.status_code;
      last      <= 1'b1;
    end else if (cmd.load_rdata) begin
      value_out <= $signed(rdata);
      status    <= ST_OK;
      last      <= cmd.rdata_last;
    end
  end

  always_comb begin
    stat.full     = (count == CNT_W'(DEPTH));
    stat.empty    = (count == '0);
    stat.list_end = ((CNT_W'(offset) + CNT_W'(1)) == count);
    stat.out_last = last;
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("item count exceeds depth");

  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.push_front, cmd.push_rear, cmd.pop_front, cmd.pop_rear,
              cmd.list_start, cmd.list_next}))
    else $error("more than one queue action in a cycle");

  a_push_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.push_front || cmd.push_rear) |=> count == $past(count) + CNT_W'(1))
    else $error("push did not add one item");

  a_pop_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop_front || cmd.pop_rear) |=> count == $past(count) - CNT_W'(1))
    else $error("pop did not remove one item");

endmodule

`default_nettype wire

@@ sv/bdq_ctrl.sv @@
// Controller of the bounded deque: decodes requests, sequences memory reads and
// the list walk, and runs both handshakes. Depends on bdq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdq_ctrl
  import bdq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_cmd,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire dp_stat_t         stat,
  output dp_cmd_t               cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state, state_next;
  logic       listing, listing_next;
  logic       accept;

  // A new request may enter in the cycle the final result of the last one is taken.
  assign in_ready  = (state == S_IDLE) || ((state == S_OUT) && stat.out_last && out_ready);
  assign out_valid = (state == S_OUT);
  assign accept    = in_valid && in_ready;

  always_comb begin
    cmd          = '0;
    state_next   = state;
    listing_next = listing;

    if (state == S_READ) begin
      cmd.load_rdata = 1'b1;
      cmd.rdata_last = listing ? stat.list_end : 1'b1;
      state_next     = S_OUT;
    end

    if ((state == S_OUT) && out_ready) begin
      if (!stat.out_last) begin
        cmd.list_next = 1'b1;
        state_next    = S_READ;
      end else begin
        state_next = S_IDLE;
      end
    end

    if (accept) begin
      listing_next = 1'b0;
      unique case (in_cmd)
        CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
          cmd.load_status = 1'b1;
          if (stat.full) begin
            cmd.status_code = ST_FULL;
          end else begin
            cmd.status_code = ST_OK;
            cmd.push_front  = (in_cmd == CMD_PUSH_FRONT);
            cmd.push_rear   = (in_cmd == CMD_PUSH_REAR);
          end
          state_next = S_OUT;
        end
        CMD_POP_FRONT, CMD_POP_REAR, CMD_LIST: begin
          if (stat.empty) begin
            cmd.load_status = 1'b1;
            cmd.status_code = ST_EMPTY;
            state_next      = S_OUT;
          end else begin
            cmd.pop_front  = (in_cmd == CMD_POP_FRONT);
            cmd.pop_rear   = (in_cmd == CMD_POP_REAR);
            cmd.list_start = (in_cmd == CMD_LIST);
            listing_next   = (in_cmd == CMD_LIST);
            state_next     = S_READ;
          end
        end
        default: begin
          // Unknown commands are dropped without a result.
          state_next = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      listing <= 1'b0;
    end else begin
      state   <= state_next;
      listing <= listing_next;
    end
  end

  a_read_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |=> (state == S_OUT)) else $error("read data not presented");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_ready) |=> (state == S_OUT))
    else $error("result dropped while receiver stalled");

  a_walk_is_list: assert property (@(posedge clk) disable iff (rst)
    cmd.list_next |-> listing) else $error("list walk outside a list request");

  a_no_load_clash: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_status && cmd.load_rdata)) else $error("two result loads in one cycle");

endmodule

`default_nettype wire

@@ sv/bounded_deque_unit.sv @@
// Bounded double-ended queue of signed 32-bit words.
// Requests arrive on req (cmd, value_in); results leave on rsp (value_out, status, last)
// under valid/ready handshakes, accepted when valid and ready are both high.
// Commands: push front, push rear, pop front, pop rear, list. Other codes are dropped.
// A push gives one result (ok or full); a pop gives the removed word or an empty status.
// A list gives every stored word from front to rear with last on the rear word, or one
// empty status when nothing is stored.
// A push result is loaded straight into the output register; a pop result first
// passes the registered read port of the word memory, then the output register. Each
// list word after the first does the same once the previous word is taken.
// Push and status-only requests are taken every cycle while rsp is ready, pops are not.
// A new request is taken in the cycle the final result of the previous one is taken.
// When the receiver stalls, the result is held in the output register and no new
// request is taken. Reset (rst, synchronous) empties the queue: head and count go to
// zero; stored words are not cleared and read only after being written.
// Uses bdq_pkg, bdq_in_if, bdq_out_if, bdq_ctrl and bdq_dp.
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_unit
  import bdq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  bdq_in_if.sink    req,
  bdq_out_if.source rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  bdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_cmd    (req.cmd),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bdq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value_in  (req.value_in),
    .stat      (stat),
    .value_out (rsp.value_out),
    .status    (rsp.status),
    .last      (rsp.last)
  );

  assign req.ready = in_ready;
  assign rsp.valid = out_valid;

endmodule

`default_nettype wire
